FILE: hw/rtl/pn2d_pkg.sv
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types and constants of the octave Perlin noise block.
// ----------------------------------------------------------------------------
package pn2d_pkg;

    localparam int DEF_MAX_OCTAVES   = 8;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int TABLE_SIZE        = 256;
    localparam int TABLE_AW          = 8;
    localparam int OCT_LAST_STEP     = 18;
    localparam int STEP_W            = 5;

    localparam logic       REG_OCTAVE_COUNT    = 1'b0;
    localparam logic       REG_AMPLITUDE_DECAY = 1'b1;
    localparam logic [3:0] OCTAVE_COUNT_RST    = 4'd4;
    localparam logic [15:0] AMPLITUDE_DECAY_RST = 16'd32768;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OCT,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        RS_CX,
        RS_CX1,
        RS_HA,
        RS_HA1,
        RS_HB,
        RS_HB1,
        RS_PA0,
        RS_PA1,
        RS_PB0,
        RS_PB1
    } t_rsel;

    typedef enum logic [3:0] {
        CP_NONE,
        CP_HA,
        CP_HB,
        CP_PA0,
        CP_PA1,
        CP_PB0,
        CP_PB1,
        CP_H00,
        CP_H01,
        CP_H10,
        CP_H11
    } t_cap;

    typedef enum logic [3:0] {
        MO_NONE,
        MO_F1X,
        MO_F2X,
        MO_F3X,
        MO_F1Y,
        MO_F2Y,
        MO_F3Y,
        MO_BL0,
        MO_BL1,
        MO_BLY,
        MO_ACC,
        MO_GAIN
    } t_mop;

    typedef struct packed {
        logic  wr_en;
        logic  start;
        t_rsel rsel;
        t_cap  cap;
        t_mop  mop;
        logic  lat_sx;
        logic  lat_sy;
        logic  lat_row0;
        logic  lat_row1;
        logic  lat_layer;
        logic  acc_en;
        logic  next_oct;
        logic  div_start;
        logic  div_step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic last_oct;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/pn2d_ctrl.sv
// ----------------------------------------------------------------------------
// pn2d_ctrl
// Sequencer: per-octave step schedule, division loop and result handoff.
// ----------------------------------------------------------------------------
module pn2d_ctrl import pn2d_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_mode,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rsel = RS_CX;
        o_cmd.cap  = CP_NONE;
        o_cmd.mop  = MO_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == MODE_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_OCT;
                        n_step      = '0;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_OCT: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    5'd0: begin
                        o_cmd.rsel = RS_CX;  o_cmd.mop = MO_F1X;
                    end
                    5'd1: begin
                        o_cmd.rsel = RS_CX1; o_cmd.mop = MO_F2X; o_cmd.cap = CP_HA;
                    end
                    5'd2: begin
                        o_cmd.rsel = RS_HA;  o_cmd.mop = MO_F3X; o_cmd.cap = CP_HB;
                    end
                    5'd3: begin
                        o_cmd.rsel = RS_HA1; o_cmd.mop = MO_F3X; o_cmd.cap = CP_PA0;
                    end
                    5'd4: begin
                        o_cmd.rsel = RS_HB;  o_cmd.mop = MO_F1Y; o_cmd.cap = CP_PA1;
                        o_cmd.lat_sx = 1'b1;
                    end
                    5'd5: begin
                        o_cmd.rsel = RS_HB1; o_cmd.mop = MO_F2Y; o_cmd.cap = CP_PB0;
                    end
                    5'd6: begin
                        o_cmd.rsel = RS_PA0; o_cmd.mop = MO_F3Y; o_cmd.cap = CP_PB1;
                    end
                    5'd7: begin
                        o_cmd.rsel = RS_PA1; o_cmd.mop = MO_F3Y; o_cmd.cap = CP_H00;
                    end
                    5'd8: begin
                        o_cmd.rsel = RS_PB0; o_cmd.cap = CP_H01; o_cmd.lat_sy = 1'b1;
                    end
                    5'd9: begin
                        o_cmd.rsel = RS_PB1; o_cmd.cap = CP_H10;
                    end
                    5'd10: o_cmd.cap = CP_H11;
                    5'd11: o_cmd.mop = MO_BL0;
                    5'd12: begin
                        o_cmd.lat_row0 = 1'b1; o_cmd.mop = MO_BL1;
                    end
                    5'd13: o_cmd.lat_row1 = 1'b1;
                    5'd14: o_cmd.mop = MO_BLY;
                    5'd15: o_cmd.lat_layer = 1'b1;
                    5'd16: o_cmd.mop = MO_ACC;
                    5'd17: begin
                        o_cmd.acc_en = 1'b1; o_cmd.mop = MO_GAIN;
                    end
                    default: begin
                        o_cmd.next_oct = 1'b1;
                        n_step         = '0;
                        if (i_sts.last_oct) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/pn2d_dp.sv
// ----------------------------------------------------------------------------
// pn2d_dp
// Datapath: permutation memory, shared multiplier, accumulator, divider.
// ----------------------------------------------------------------------------
module pn2d_dp import pn2d_pkg::*; #(
    parameter int MAX_OCTAVES   = DEF_MAX_OCTAVES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_tidx,
    input  logic [7:0]  i_tval,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [15:0] o_out_data
);

    localparam int PW = FRACTION_BITS + 8;
    localparam int OW = $clog2(MAX_OCTAVES + 1);
    localparam int AW = 37 + $clog2(MAX_OCTAVES);
    localparam int TW = 17 + $clog2(MAX_OCTAVES);
    localparam int DW = TW + 2;
    localparam int CW = $clog2(AW + 1);

    logic [3:0]  r_oc;
    logic [15:0] r_decay;
    logic [7:0]  r_mem [TABLE_SIZE];
    logic [7:0]  r_rdata;
    logic [7:0]  raddr;
    logic [PW-1:0] r_px, r_py;
    logic [7:0]  r_ha, r_hb, r_pa0, r_pa1, r_pb0, r_pb1;
    logic [1:0]  r_h00, r_h01, r_h10, r_h11;
    logic signed [39:0] r_prod;
    logic [16:0] r_sx, r_sy, r_gain;
    logic signed [18:0] r_row0, r_row1, r_layer;
    logic [TW-1:0] r_total;
    logic signed [AW-1:0] r_acc;
    logic [OW-1:0] r_oct;
    logic [DW-1:0] r_rem;
    logic [AW-1:0] r_quo;
    logic r_neg;
    logic [CW-1:0] r_dcnt;
    logic r_ovalid;
    logic [15:0] r_odata;

    logic [15:0] fx, fy;
    logic [7:0]  cx, cy;
    logic signed [18:0] dx0, dx1, dy0, dy1, d00, d01, d10, d11;
    logic signed [39:0] prod_sh;
    logic signed [21:0] sh22;
    logic signed [17:0] op_a;
    logic signed [21:0] op_b;
    logic [16:0] fade_clamp;
    logic [OW-1:0] eff_m1;
    logic [DW-1:0] denom;
    logic [DW:0] rem_sh, rem_diff;
    logic signed [AW:0] qmag, qs;
    logic [15:0] qsat;
    logic rem_nz;

    function automatic logic signed [18:0] f_dot(input logic [1:0] h,
                                                 input logic signed [18:0] a,
                                                 input logic signed [18:0] b);
        logic signed [18:0] f, s;
        f = h[1] ? b : a;
        s = h[1] ? a : b;
        if (h[0]) f = -f;
        if (h[1]) s = -s;
        return f + s;
    endfunction

    generate
        if (FRACTION_BITS >= 16) begin : g_frac_hi
            assign fx = r_px[FRACTION_BITS-1 -: 16];
            assign fy = r_py[FRACTION_BITS-1 -: 16];
        end else begin : g_frac_lo
            assign fx = {r_px[FRACTION_BITS-1:0], {(16-FRACTION_BITS){1'b0}}};
            assign fy = {r_py[FRACTION_BITS-1:0], {(16-FRACTION_BITS){1'b0}}};
        end
    endgenerate

    assign cx  = r_px[PW-1 -: 8];
    assign cy  = r_py[PW-1 -: 8];
    assign dx0 = $signed({3'b000, fx});
    assign dy0 = $signed({3'b000, fy});
    assign dx1 = dx0 - 19'sd65536;
    assign dy1 = dy0 - 19'sd65536;
    assign d00 = f_dot(r_h00, dx0, dy0);
    assign d10 = f_dot(r_h10, dx1, dy0);
    assign d01 = f_dot(r_h01, dx0, dy1);
    assign d11 = f_dot(r_h11, dx1, dy1);
    assign prod_sh = r_prod >>> 16;
    assign sh22 = prod_sh[21:0];

    always_comb begin
        if (prod_sh < 40'sd0) begin
            fade_clamp = '0;
        end else if (prod_sh > 40'sd65536) begin
            fade_clamp = 17'd65536;
        end else begin
            fade_clamp = prod_sh[16:0];
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.mop)
            MO_F1X: begin
                op_a = $signed({2'b00, fx});
                op_b = $signed(({6'd0, fx} << 2) + ({6'd0, fx} << 1)) - 22'sd983040;
            end
            MO_F2X: begin
                op_a = $signed({2'b00, fx}); op_b = sh22 + 22'sd655360;
            end
            MO_F3X: begin
                op_a = $signed({2'b00, fx}); op_b = sh22;
            end
            MO_F1Y: begin
                op_a = $signed({2'b00, fy});
                op_b = $signed(({6'd0, fy} << 2) + ({6'd0, fy} << 1)) - 22'sd983040;
            end
            MO_F2Y: begin
                op_a = $signed({2'b00, fy}); op_b = sh22 + 22'sd655360;
            end
            MO_F3Y: begin
                op_a = $signed({2'b00, fy}); op_b = sh22;
            end
            MO_BL0: begin
                op_a = $signed({1'b0, r_sx}); op_b = 22'(d10) - 22'(d00);
            end
            MO_BL1: begin
                op_a = $signed({1'b0, r_sx}); op_b = 22'(d11) - 22'(d01);
            end
            MO_BLY: begin
                op_a = $signed({1'b0, r_sy}); op_b = 22'(r_row1) - 22'(r_row0);
            end
            MO_ACC: begin
                op_a = $signed({1'b0, r_gain}); op_b = 22'(r_layer);
            end
            MO_GAIN: begin
                op_a = $signed({1'b0, r_gain}); op_b = $signed({6'd0, r_decay});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.rsel)
            RS_CX:   raddr = cx;
            RS_CX1:  raddr = cx + 8'd1;
            RS_HA:   raddr = r_ha;
            RS_HA1:  raddr = r_ha + 8'd1;
            RS_HB:   raddr = r_hb;
            RS_HB1:  raddr = r_hb + 8'd1;
            RS_PA0:  raddr = r_pa0;
            RS_PA1:  raddr = r_pa1;
            RS_PB0:  raddr = r_pb0;
            RS_PB1:  raddr = r_pb1;
            default: raddr = cx;
        endcase
    end

    always_comb begin
        if (r_oc == 4'd0) begin
            eff_m1 = '0;
        end else if (int'(r_oc) > MAX_OCTAVES) begin
            eff_m1 = OW'(MAX_OCTAVES - 1);
        end else begin
            eff_m1 = OW'(int'(r_oc) - 1);
        end
    end

    assign denom    = {r_total, 2'b00};
    assign rem_sh   = {r_rem, r_quo[AW-1]};
    assign rem_diff = rem_sh - {1'b0, denom};
    assign rem_nz   = (r_rem != '0);
    assign qmag     = $signed({1'b0, r_quo});
    assign qs       = r_neg ? (-qmag - $signed({{AW{1'b0}}, rem_nz})) : qmag;

    always_comb begin
        if (qs > (AW+1)'(32767)) begin
            qsat = 16'h7fff;
        end else if (qs < -(AW+1)'(32768)) begin
            qsat = 16'h8000;
        end else begin
            qsat = qs[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_tidx] <= i_tval;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc    <= OCTAVE_COUNT_RST;
            r_decay <= AMPLITUDE_DECAY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OCTAVE_COUNT:    r_oc    <= i_cfg_data[3:0];
                REG_AMPLITUDE_DECAY: r_decay <= i_cfg_data;
                default:             r_oc    <= r_oc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.cap)
            CP_HA:   r_ha  <= r_rdata + cy;
            CP_HB:   r_hb  <= r_rdata + cy;
            CP_PA0:  r_pa0 <= r_rdata;
            CP_PA1:  r_pa1 <= r_rdata;
            CP_PB0:  r_pb0 <= r_rdata;
            CP_PB1:  r_pb1 <= r_rdata;
            CP_H00:  r_h00 <= r_rdata[1:0];
            CP_H01:  r_h01 <= r_rdata[1:0];
            CP_H10:  r_h10 <= r_rdata[1:0];
            CP_H11:  r_h11 <= r_rdata[1:0];
            default: r_ha  <= r_ha;
        endcase
        if (i_cmd.mop != MO_NONE) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.lat_sx)    r_sx    <= fade_clamp;
        if (i_cmd.lat_sy)    r_sy    <= fade_clamp;
        if (i_cmd.lat_row0)  r_row0  <= d00 + prod_sh[18:0];
        if (i_cmd.lat_row1)  r_row1  <= d01 + prod_sh[18:0];
        if (i_cmd.lat_layer) r_layer <= r_row0 + prod_sh[18:0];
        if (i_cmd.start) begin
            r_px    <= i_x[PW-1:0];
            r_py    <= i_y[PW-1:0];
            r_acc   <= '0;
            r_total <= '0;
            r_gain  <= 17'd65536;
            r_oct   <= '0;
        end else begin
            if (i_cmd.acc_en) begin
                r_acc   <= r_acc + AW'(r_prod);
                r_total <= r_total + TW'(r_gain);
            end
            if (i_cmd.next_oct) begin
                r_px   <= r_px << 1;
                r_py   <= r_py << 1;
                r_oct  <= r_oct + 1'b1;
                r_gain <= prod_sh[16:0];
            end
        end
        if (i_cmd.div_start) begin
            r_neg  <= r_acc[AW-1];
            r_quo  <= r_acc[AW-1] ? AW'(-r_acc) : r_acc;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (!rem_diff[DW]) begin
                r_rem <= rem_diff[DW-1:0];
                r_quo <= {r_quo[AW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DW-1:0];
                r_quo <= {r_quo[AW-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_odata <= qsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.last_oct = (r_oct == eff_m1);
    assign o_sts.div_done = (r_dcnt == CW'(AW));
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_odata;

endmodule

FILE: hw/rtl/perlin_noise_2d_octaves.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_octaves
// Two-dimensional improved Perlin noise summed over octaves, normalized.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser mode, tdata 80 bits
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata noise_value
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// A load transfer writes the permutation memory and leaves the input ready. An
// evaluation steps through each octave on the shared multiplier and single memory
// read port, then runs a restoring division and hands the result to the output.
// Reset is synchronous; the permutation memory is not cleared.
// A stalled result holds in the output register until it is taken.
// ----------------------------------------------------------------------------
module perlin_noise_2d_octaves import pn2d_pkg::*; #(
    parameter int MAX_OCTAVES   = DEF_MAX_OCTAVES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // table_index, table_value, x_coord, y_coord
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // noise_value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    pn2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pn2d_dp #(
        .MAX_OCTAVES   (MAX_OCTAVES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_tidx      (s_axis_tdata[7:0]),
        .i_tval      (s_axis_tdata[15:8]),
        .i_x         (s_axis_tdata[47:16]),
        .i_y         (s_axis_tdata[79:48]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = in_ready;
    assign o_cfg_ready   = 1'b1;

endmodule

FILE: hw/rtl/pn2d_chk.sv
// ----------------------------------------------------------------------------
// pn2d_chk
// Port-level checks of the octave Perlin noise block.
// ----------------------------------------------------------------------------
module pn2d_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [79:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_cfg_index,
    input logic [15:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input accepted during an evaluation");

    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
        else $error("load transfer stalled the input");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an evaluation in progress");

endmodule

bind perlin_noise_2d_octaves pn2d_chk u_pn2d_chk (.*);
